>>> sv/lidar_point_ring_transform_crop_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef LIDAR_POINT_RING_TRANSFORM_CROP_MACROS_SVH
`define LIDAR_POINT_RING_TRANSFORM_CROP_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define LPRTC_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lidar crop check failed");

// Clocked assertion that also holds while reset is high.
`define LPRTC_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lidar crop check failed");

`endif

>>> sv/lprtc_pkg.sv
package lprtc_pkg;

  localparam int COORD_BITS      = 18;
  localparam int RING_COUNT      = 16;
  localparam int COEFF_FRAC_BITS = 16;

  localparam int COORD_W  = COORD_BITS;
  localparam int COEFF_W  = COEFF_FRAC_BITS + 4;
  localparam int PROD_W   = COORD_W + COEFF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int SUM_W    = ACC_W - COEFF_FRAC_BITS + 1;
  localparam int R2_W     = 2 * COORD_W;
  localparam int Z2_W     = 2 * COORD_W - 1;
  localparam int TAN_W    = 21;
  localparam int TAN_FRAC = 24;
  localparam int TAN_N    = 9;
  localparam int PP_W     = COORD_W + TAN_W;
  localparam int CMP_W    = Z2_W + TAN_FRAC;
  localparam int RING_W     = $clog2(RING_COUNT);
  localparam int RING_IDX_W = RING_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = COORD_W;
  localparam int HALF_W     = COORD_W - 1;
  localparam int STAGES     = 5;
  localparam int TRANS_COL  = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [TAN_W-1:0]          tan_t;
  typedef logic [CFG_W-1:0]          cfg_data_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic              drop;
  } elev_res_t;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 2'd3;

  localparam coord_t              NEAR_X_RESET  = coord_t'(500);
  localparam coord_t              FAR_X_RESET   = coord_t'(20000);
  localparam logic [HALF_W-1:0]   HALF_Y_RESET  = HALF_W'(12000);
  localparam coord_t              CEILING_RESET = coord_t'(-1300);

  localparam coord_t COORD_MAX   = coord_t'(2 ** (COORD_W - 1) - 1);
  localparam coord_t COORD_MIN   = coord_t'(-(2 ** (COORD_W - 1)));
  localparam sum_t   COORD_MAX_S = sum_t'(2 ** (COORD_W - 1) - 1);
  localparam sum_t   COORD_MIN_S = sum_t'(-(2 ** (COORD_W - 1)));
  localparam acc_t   ROUND_HALF  = acc_t'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic [RING_W-1:0] RING_MID = RING_W'(RING_COUNT / 2);

  // Squared tangent of the even boundary angles 2, 4, ... 18 degrees, scaled by 2^24.
  localparam tan_t TAN_SQ [TAN_N] = '{
    tan_t'(20459),   tan_t'(82037),   tan_t'(185336),
    tan_t'(331379),  tan_t'(521624),  tan_t'(758000),
    tan_t'(1042946), tan_t'(1379472), tan_t'(1771218)
  };

  // Calibration in millionths, left sensor first, rows of three coefficients and a translation.
  localparam int CALIB_MICRO [24] = '{
    115046, -993042, 25125, -321385,
    735849, 102186, 669391, 678507,
    -667301, -58523, 742485, -354922,
    -34197, 999413, 2200, -342517,
    -759464, -24556, -650086, -759176,
    -649650, -23902, 759857, -323078
  };

  function automatic coeff_t calib_entry(input int idx);
    longint mag;
    longint q;
    mag = (CALIB_MICRO[idx] < 0) ? -longint'(CALIB_MICRO[idx]) : longint'(CALIB_MICRO[idx]);
    if (idx % 4 == TRANS_COL) begin
      q = (mag + 500) / 1000;
    end else begin
      q = ((mag << COEFF_FRAC_BITS) + 500000) / 1000000;
    end
    return (CALIB_MICRO[idx] < 0) ? coeff_t'(-q) : coeff_t'(q);
  endfunction

  localparam coeff_t CALIB [2][3][4] = '{
    '{
      '{calib_entry(0),  calib_entry(1),  calib_entry(2),  calib_entry(3)},
      '{calib_entry(4),  calib_entry(5),  calib_entry(6),  calib_entry(7)},
      '{calib_entry(8),  calib_entry(9),  calib_entry(10), calib_entry(11)}
    },
    '{
      '{calib_entry(12), calib_entry(13), calib_entry(14), calib_entry(15)},
      '{calib_entry(16), calib_entry(17), calib_entry(18), calib_entry(19)},
      '{calib_entry(20), calib_entry(21), calib_entry(22), calib_entry(23)}
    }
  };

endpackage

>>> sv/lprtc_elev.sv
module lprtc_elev (
  input  logic                clk,
  input  lprtc_pkg::stage_en_t en,
  input  lprtc_pkg::coord_t   x,
  input  lprtc_pkg::coord_t   y,
  input  lprtc_pkg::coord_t   z,
  output lprtc_pkg::elev_res_t res
);
  import lprtc_pkg::*;

  logic [COORD_W-1:0] ax, ay, az;
  logic [R2_W-1:0]    sqx, sqy, sqz;

  logic [R2_W-1:0] r2;
  logic [Z2_W-1:0] z2;
  logic            zneg2, zpos2;

  logic [PP_W-1:0] ph [TAN_N];
  logic [PP_W-1:0] pl [TAN_N];
  logic [Z2_W-1:0] z2_3;
  logic            r2_zero3, zneg3, zpos3;

  logic [CMP_W-1:0] rt [TAN_N];
  logic [CMP_W-1:0] zs;

  logic [TAN_N-1:0] le4, ge4;
  logic             r2_zero4, zneg4, zpos4;

  logic [RING_W-1:0] cnt_le, cnt_ge;

  always_comb begin
    ax  = x[COORD_W-1] ? COORD_W'(-x) : COORD_W'(x);
    ay  = y[COORD_W-1] ? COORD_W'(-y) : COORD_W'(y);
    az  = z[COORD_W-1] ? COORD_W'(-z) : COORD_W'(z);
    sqx = R2_W'(ax) * R2_W'(ax);
    sqy = R2_W'(ay) * R2_W'(ay);
    sqz = R2_W'(az) * R2_W'(az);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      r2    <= sqx + sqy;
      z2    <= sqz[Z2_W-1:0];
      zneg2 <= z[COORD_W-1];
      zpos2 <= !z[COORD_W-1] && (z != '0);
    end
    if (en.s3) begin
      for (int i = 0; i < TAN_N; i++) begin
        ph[i] <= PP_W'(r2[R2_W-1:COORD_W]) * PP_W'(TAN_SQ[i]);
        pl[i] <= PP_W'(r2[COORD_W-1:0]) * PP_W'(TAN_SQ[i]);
      end
      z2_3     <= z2;
      r2_zero3 <= (r2 == '0);
      zneg3    <= zneg2;
      zpos3    <= zpos2;
    end
    if (en.s4) begin
      for (int i = 0; i < TAN_N; i++) begin
        le4[i] <= (zs <= rt[i]);
        ge4[i] <= (zs >= rt[i]);
      end
      r2_zero4 <= r2_zero3;
      zneg4    <= zneg3;
      zpos4    <= zpos3;
    end
  end

  always_comb begin
    zs = CMP_W'(z2_3) << TAN_FRAC;
    for (int i = 0; i < TAN_N; i++) begin
      rt[i] = (CMP_W'(ph[i]) << COORD_W) + CMP_W'(pl[i]);
    end
  end

  // The boundary tests form a thermometer code, so the ring is a count of passed boundaries.
  always_comb begin
    cnt_le = '0;
    cnt_ge = '0;
    for (int i = 0; i < TAN_N - 2; i++) begin
      cnt_le = cnt_le + RING_W'(le4[i]);
      cnt_ge = cnt_ge + RING_W'(ge4[i]);
    end
    res.drop = r2_zero4 || (zneg4 && ge4[TAN_N-1]) || (zpos4 && ge4[TAN_N-2]);
    if (zneg4) begin
      res.ring = cnt_le;
    end else if (zpos4) begin
      res.ring = RING_MID + cnt_ge;
    end else begin
      res.ring = RING_MID;
    end
  end

endmodule

>>> sv/lprtc_xform.sv
module lprtc_xform (
  input  logic                 clk,
  input  lprtc_pkg::stage_en_t en,
  input  logic                 side,
  input  lprtc_pkg::coord_t    x,
  input  lprtc_pkg::coord_t    y,
  input  lprtc_pkg::coord_t    z,
  output lprtc_pkg::coord_t    tx,
  output lprtc_pkg::coord_t    ty,
  output lprtc_pkg::coord_t    tz
);
  import lprtc_pkg::*;

  coord_t pin [3];
  prod_t  prod [3][3];
  coeff_t tr2 [3];
  coeff_t tr3 [3];
  acc_t   acc [3];
  acc_t   rnd [3];
  sum_t   total [3];
  coord_t sat [3];
  coord_t t4 [3];

  always_comb begin
    pin[0] = x;
    pin[1] = y;
    pin[2] = z;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= prod_t'(CALIB[side][r][c]) * prod_t'(pin[c]);
        end
        tr2[r] <= CALIB[side][r][TRANS_COL];
      end
    end
    if (en.s3) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= acc_t'(prod[r][0]) + acc_t'(prod[r][1]) + acc_t'(prod[r][2]);
        tr3[r] <= tr2[r];
      end
    end
    if (en.s4) begin
      for (int r = 0; r < 3; r++) begin
        t4[r] <= sat[r];
      end
    end
  end

  // Round to nearest with ties upward, add the translation, then clamp to the coordinate range.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r]   = (acc[r] + ROUND_HALF) >>> COEFF_FRAC_BITS;
      total[r] = sum_t'(rnd[r]) + sum_t'(tr3[r]);
      if (total[r] > COORD_MAX_S) begin
        sat[r] = COORD_MAX;
      end else if (total[r] < COORD_MIN_S) begin
        sat[r] = COORD_MIN;
      end else begin
        sat[r] = total[r][COORD_W-1:0];
      end
    end
  end

  assign tx = t4[0];
  assign ty = t4[1];
  assign tz = t4[2];

endmodule

>>> sv/lprtc_crop.sv
module lprtc_crop (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [lprtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  lprtc_pkg::cfg_data_t                cfg_data,
  input  lprtc_pkg::coord_t                   tx,
  input  lprtc_pkg::coord_t                   ty,
  input  lprtc_pkg::coord_t                   tz,
  output logic                                keep
);
  import lprtc_pkg::*;

  coord_t              near_x_limit;
  coord_t              far_x_limit;
  logic [HALF_W-1:0]   half_width_y;
  coord_t              height_ceiling_z;
  logic [COORD_W-1:0]  ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_x_limit     <= NEAR_X_RESET;
      far_x_limit      <= FAR_X_RESET;
      half_width_y     <= HALF_Y_RESET;
      height_ceiling_z <= CEILING_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_NEAR_X:  near_x_limit     <= cfg_data;
        CFG_FAR_X:   far_x_limit      <= cfg_data;
        CFG_HALF_Y:  half_width_y     <= cfg_data[HALF_W-1:0];
        CFG_CEILING: height_ceiling_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ay   = ty[COORD_W-1] ? COORD_W'(-ty) : COORD_W'(ty);
    keep = (tx > near_x_limit) && (tx < far_x_limit)
        && (ay < {1'b0, half_width_y}) && (tz < height_ceiling_z);
  end

endmodule

>>> sv/lidar_point_ring_transform_crop.sv
// Takes one lidar point per clock from either sensor and returns it, transformed into the
// common frame and tagged with its elevation ring, if it survives the ring and crop tests;
// dropped points give no item at all. The block is a five-stage pipeline: input register,
// squares and calibration products, range-times-tangent partial products and row sums,
// boundary compares and rounding, then ring count and crop test into the output register.
// A new point can be taken every cycle while in_stall is low; empty stages close up, so a
// stalled output only holds the input once every stage is full. Crop limits may be written
// whenever the block is idle.
module lidar_point_ring_transform_crop (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 sensor_side,
  input  logic                                 point_valid,
  input  lprtc_pkg::coord_t                    raw_x,
  input  lprtc_pkg::coord_t                    raw_y,
  input  lprtc_pkg::coord_t                    raw_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lprtc_pkg::coord_t                    out_x,
  output lprtc_pkg::coord_t                    out_y,
  output lprtc_pkg::coord_t                    out_z,
  output logic [lprtc_pkg::RING_IDX_W-1:0]     ring_index,
  input  logic                                 cfg_write_enable,
  input  logic [lprtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  lprtc_pkg::cfg_data_t                 cfg_data
);
  import lprtc_pkg::*;

  logic [STAGES-2:0] vld;
  logic [STAGES-1:0] rdy;
  logic              side_pipe [STAGES-1];
  coord_t            x1, y1, z1;
  coord_t            tx, ty, tz;
  stage_en_t         en;
  elev_res_t         res;
  logic              keep;

  always_comb begin
    rdy[STAGES-1] = !out_valid || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];
  assign en.s2    = rdy[1];
  assign en.s3    = rdy[2];
  assign en.s4    = rdy[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid && point_valid;
      end
      for (int i = 1; i < STAGES - 1; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (rdy[STAGES-1]) begin
        out_valid <= vld[STAGES-2] && !res.drop && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side_pipe[0] <= sensor_side;
      x1           <= raw_x;
      y1           <= raw_y;
      z1           <= raw_z;
    end
    for (int i = 1; i < STAGES - 1; i++) begin
      if (rdy[i]) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
    if (rdy[STAGES-1]) begin
      out_x      <= tx;
      out_y      <= ty;
      out_z      <= tz;
      ring_index <= {side_pipe[STAGES-2], res.ring};
    end
  end

  lprtc_elev u_elev (
    .clk (clk),
    .en  (en),
    .x   (x1),
    .y   (y1),
    .z   (z1),
    .res (res)
  );

  lprtc_xform u_xform (
    .clk  (clk),
    .en   (en),
    .side (side_pipe[0]),
    .x    (x1),
    .y    (y1),
    .z    (z1),
    .tx   (tx),
    .ty   (ty),
    .tz   (tz)
  );

  lprtc_crop u_crop (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .tx               (tx),
    .ty               (ty),
    .tz               (tz),
    .keep             (keep)
  );

endmodule

>>> sv/lprtc_checker.sv
`include "lidar_point_ring_transform_crop_macros.svh"

module lprtc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input lprtc_pkg::coord_t                 out_x,
  input lprtc_pkg::coord_t                 out_y,
  input lprtc_pkg::coord_t                 out_z,
  input logic [lprtc_pkg::RING_IDX_W-1:0]  ring_index
);

  property p_out_stable;
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
      && $stable(ring_index);
  endproperty

  // Reset empties the pipeline, so no item can be shown in the following cycle.
  `LPRTC_ASSERT(a_reset_empties, clk, rst |=> !out_valid)

  // The input only backs up when the output holds an item that is being refused.
  `LPRTC_ASSERT_RST(a_stall_needs_full, clk, rst, in_stall |-> out_valid && out_stall)

  `LPRTC_ASSERT_RST(a_out_held, clk, rst, out_valid && out_stall |=> out_valid)

  `LPRTC_ASSERT_RST(a_out_stable, clk, rst, p_out_stable)

endmodule

bind lidar_point_ring_transform_crop lprtc_checker u_lprtc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_z      (out_z),
  .ring_index (ring_index)
);

>>> tb/sv/lidar_point_ring_transform_crop_test.sv
module lidar_point_ring_transform_crop_test;
  import lprtc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam longint HALF_TOP = (longint'(1) << HALF_W) - 1;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic [RING_IDX_W-1:0] ring;
  } crop_point_t;

  typedef enum {STEP_POINT, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t kind;
    bit from_model;
    logic side;
    logic pv;
    int x;
    int y;
    int z;
    logic [CFG_IDX_W-1:0] idx;
    int value;
  } step_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic sensor_side;
  logic point_valid;
  coord_t raw_x;
  coord_t raw_y;
  coord_t raw_z;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic [RING_IDX_W-1:0] ring_index;
  logic cfg_write_enable;
  logic [CFG_IDX_W-1:0] cfg_index;
  cfg_data_t cfg_data;

  crop_point_t kept_points_due[$];
  step_t directed_steps[$];
  int mismatches = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  longint near_lim;
  longint far_lim;
  longint half_lim;
  longint ceil_lim;
  longint calib_q [24];

  longint unsigned tan_sq_q24 [10] = '{
    0, 20459, 82037, 185336, 331379, 521624, 758000, 1042946, 1379472, 1771218
  };

  longint calib_millionths [24] = '{
    115046, -993042, 25125, -321385,
    735849, 102186, 669391, 678507,
    -667301, -58523, 742485, -354922,
    -34197, 999413, 2200, -342517,
    -759464, -24556, -650086, -759176,
    -649650, -23902, 759857, -323078
  };

  lidar_point_ring_transform_crop dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sensor_side(sensor_side),
    .point_valid(point_valid),
    .raw_x(raw_x),
    .raw_y(raw_y),
    .raw_z(raw_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .ring_index(ring_index),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lidar_point_ring_transform_crop_test: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < snk_idle_pct);
  end

  // Ring from the elevation, then the side's rigid transform, then the crop box.
  function automatic bit transform_and_crop(input logic side, input logic pv, input coord_t px,
                                            input coord_t py, input coord_t pz,
                                            output crop_point_t res);
    longint p [3];
    longint t [3];
    longint acc;
    logic [79:0] r2;
    logic [79:0] z2s;
    int ring;
    int a;
    int base;
    bit hit;
    res = '0;
    if (!pv) return 0;
    p[0] = longint'(px);
    p[1] = longint'(py);
    p[2] = longint'(pz);
    r2 = 80'(p[0] * p[0] + p[1] * p[1]);
    z2s = 80'(p[2] * p[2]) << 24;
    if (r2 == 0) return 0;
    if (!(p[2] >= 0 || z2s < r2 * tan_sq_q24[9])) return 0;
    if (p[2] > 0 && z2s >= r2 * tan_sq_q24[8]) return 0;
    ring = 0;
    for (int k = 1; k < RING_COUNT; k++) begin
      a = 2 * k - 16;
      if (a < 0) begin
        hit = p[2] >= 0 || z2s <= r2 * tan_sq_q24[-a / 2];
      end else if (a == 0) begin
        hit = p[2] >= 0;
      end else begin
        hit = p[2] > 0 && z2s >= r2 * tan_sq_q24[a / 2];
      end
      if (hit) ring = k;
    end
    base = side ? 12 : 0;
    for (int r = 0; r < 3; r++) begin
      acc = calib_q[base + 4 * r] * p[0] + calib_q[base + 4 * r + 1] * p[1]
          + calib_q[base + 4 * r + 2] * p[2];
      acc = ((acc + (longint'(1) << (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS)
          + calib_q[base + 4 * r + 3];
      if (acc > longint'(COORD_MAX)) acc = longint'(COORD_MAX);
      else if (acc < longint'(COORD_MIN)) acc = longint'(COORD_MIN);
      t[r] = acc;
    end
    if (!(t[0] > near_lim && t[0] < far_lim)) return 0;
    if (!((t[1] < 0 ? -t[1] : t[1]) < half_lim)) return 0;
    if (!(t[2] < ceil_lim)) return 0;
    res.x = coord_t'(t[0]);
    res.y = coord_t'(t[1]);
    res.z = coord_t'(t[2]);
    res.ring = RING_IDX_W'(ring + (side ? RING_COUNT : 0));
    return 1;
  endfunction

  task automatic take_result();
    crop_point_t want;
    if (kept_points_due.size() == 0) begin
      $error("item with no point pending: x %0d y %0d z %0d ring %0d",
             out_x, out_y, out_z, ring_index);
      mismatches++;
    end else begin
      want = kept_points_due.pop_front();
      if (out_x !== want.x) begin
        $error("out_x expected %0d got %0d", want.x, out_x);
        mismatches++;
      end
      if (out_y !== want.y) begin
        $error("out_y expected %0d got %0d", want.y, out_y);
        mismatches++;
      end
      if (out_z !== want.z) begin
        $error("out_z expected %0d got %0d", want.z, out_z);
        mismatches++;
      end
      if (ring_index !== want.ring) begin
        $error("ring_index expected %0d got %0d", want.ring, ring_index);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) take_result();
  end

  task automatic push_point(input logic side, input logic pv, input coord_t px, input coord_t py,
                            input coord_t pz, input bit from_model);
    crop_point_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sensor_side <= side;
    point_valid <= pv;
    raw_x <= px;
    raw_y <= py;
    raw_z <= pz;
    do @(posedge clk); while (in_stall);
    if (from_model && transform_and_crop(side, pv, px, py, pz, res))
      kept_points_due = {kept_points_due, res};
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    in_valid <= 1'b0;
    while (kept_points_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cfg_data_t'(value);
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    case (idx)
      CFG_NEAR_X: near_lim = longint'(coord_t'(value));
      CFG_FAR_X: far_lim = longint'(coord_t'(value));
      CFG_HALF_Y: half_lim = value & HALF_TOP;
      CFG_CEILING: ceil_lim = longint'(coord_t'(value));
      default: ;
    endcase
  endtask

  task automatic set_box(input longint near, input longint far, input longint half,
                         input longint ceiling);
    write_reg(CFG_NEAR_X, near);
    write_reg(CFG_FAR_X, far);
    write_reg(CFG_HALF_Y, half);
    write_reg(CFG_CEILING, ceiling);
  endtask

  function automatic step_t point_row(input bit from_model, input logic side, input logic pv,
                                      input int x, input int y, input int z);
    step_t s;
    s.kind = STEP_POINT;
    s.from_model = from_model;
    s.side = side;
    s.pv = pv;
    s.x = x;
    s.y = y;
    s.z = z;
    s.idx = CFG_NEAR_X;
    s.value = 0;
    return s;
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int value);
    step_t s;
    s = point_row(1'b0, 1'b0, 1'b0, 0, 0, 0);
    s.kind = STEP_REG;
    s.idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic void queue_row(input step_t s);
    directed_steps = {directed_steps, s};
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(3))
      0: return COORD_MAX;
      1: return COORD_MIN;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // A point at an elevation mostly inside the ring span, at a random range.
  task automatic shaped_point(output logic side, output coord_t px, output coord_t py,
                              output coord_t pz);
    longint span;
    longint ax;
    longint ay;
    longint m;
    span = ($urandom_range(3) == 0) ? 120000 : 25000;
    side = 1'($urandom_range(1));
    ax = longint'($urandom_range(int'(2 * span))) - span;
    ay = longint'($urandom_range(int'(2 * span))) - span;
    m = (ax < 0 ? -ax : ax) > (ay < 0 ? -ay : ay) ? (ax < 0 ? -ax : ax) : (ay < 0 ? -ay : ay);
    px = coord_t'(ax);
    py = coord_t'(ay);
    pz = coord_t'((longint'($urandom_range(620)) - 330) * m / 1000);
  endtask

  task automatic run_random(input int quota);
    int sent;
    int style;
    int tries;
    logic side;
    logic pv;
    coord_t px;
    coord_t py;
    coord_t pz;
    crop_point_t scratch;
    sent = 0;
    while (sent < quota) begin
      style = $urandom_range(99);
      pv = 1'b1;
      if (style < 70) begin
        tries = 0;
        do begin
          shaped_point(side, px, py, pz);
          tries++;
        end while (!transform_and_crop(side, 1'b1, px, py, pz, scratch) && tries < 24);
      end else if (style < 80) begin
        shaped_point(side, px, py, pz);
      end else if (style < 88) begin
        side = 1'($urandom_range(1));
        px = extreme_coord();
        py = extreme_coord();
        pz = coord_t'(longint'($urandom_range(4000)) - 2000);
      end else begin
        side = 1'($urandom_range(1));
        pv = ($urandom_range(7) != 0);
        px = coord_t'($urandom);
        py = coord_t'($urandom);
        pz = coord_t'($urandom);
        if ($urandom_range(15) == 0) begin
          px = '0;
          py = '0;
        end
      end
      push_point(side, pv, px, py, pz, 1'b1);
      if (pv) sent++;
    end
  endtask

  initial begin
    longint mag;
    longint q;
    int quota;
    longint near;
    rst = 1'b1;
    in_valid = 1'b0;
    sensor_side = 1'b0;
    point_valid = 1'b0;
    raw_x = '0;
    raw_y = '0;
    raw_z = '0;
    cfg_write_enable = 1'b0;
    cfg_index = CFG_NEAR_X;
    cfg_data = '0;
    near_lim = 500;
    far_lim = 20000;
    half_lim = 12000;
    ceil_lim = -1300;
    foreach (calib_millionths[i]) begin
      mag = calib_millionths[i] < 0 ? -calib_millionths[i] : calib_millionths[i];
      if (i % 4 == 3) q = (mag + 500) / 1000;
      else q = ((mag << COEFF_FRAC_BITS) + 500000) / 1000000;
      calib_q[i] = calib_millionths[i] < 0 ? -q : q;
    end

    queue_row(point_row(1'b0, 1'b0, 1'b0, 3000, -5000, 0));
    queue_row(point_row(1'b0, 1'b1, 1'b0, int'(COORD_MAX), int'(COORD_MIN), int'(COORD_MIN)));
    queue_row(point_row(1'b0, 1'b0, 1'b1, 0, 0, 0));
    queue_row(point_row(1'b0, 1'b1, 1'b1, 0, 0, -9000));
    queue_row(point_row(1'b0, 1'b0, 1'b1, 0, 0, int'(COORD_MAX)));
    queue_row(point_row(1'b0, 1'b0, 1'b1, 1000, 0, 1000));
    queue_row(point_row(1'b0, 1'b1, 1'b1, 2000, -2000, -2000));
    queue_row(point_row(1'b1, 1'b0, 1'b1, 3000, -5000, 0));
    queue_row(point_row(1'b1, 1'b1, 1'b1, 3000, 5000, 0));
    queue_row(point_row(1'b1, 1'b0, 1'b1, 3000, -5000, -1890));
    queue_row(point_row(1'b1, 1'b0, 1'b1, 5000, -5000, 2020));
    queue_row(point_row(1'b1, 1'b0, 1'b1, 5000, -5000, 2028));
    queue_row(point_row(1'b1, 1'b1, 1'b1, 3000, 5000, -1890));
    queue_row(point_row(1'b1, 1'b1, 1'b1, 5000, 5000, 2020));
    queue_row(point_row(1'b1, 1'b0, 1'b1, 10000, 0, -3249));
    queue_row(point_row(1'b1, 1'b0, 1'b1, 10000, 0, -3250));
    queue_row(point_row(1'b1, 1'b0, 1'b1, int'(COORD_MAX), int'(COORD_MAX), 0));
    queue_row(point_row(1'b1, 1'b1, 1'b1, int'(COORD_MIN), int'(COORD_MIN), 0));
    queue_row(reg_row(CFG_NEAR_X, int'(COORD_MIN)));
    queue_row(reg_row(CFG_FAR_X, int'(COORD_MAX)));
    queue_row(reg_row(CFG_HALF_Y, int'(HALF_TOP)));
    queue_row(reg_row(CFG_CEILING, int'(COORD_MAX)));
    queue_row(point_row(1'b1, 1'b0, 1'b1, int'(COORD_MAX), int'(COORD_MIN), 0));
    queue_row(point_row(1'b1, 1'b0, 1'b1, int'(COORD_MIN), int'(COORD_MAX), -1));
    queue_row(point_row(1'b1, 1'b1, 1'b1, int'(COORD_MIN), int'(COORD_MAX), 0));
    queue_row(point_row(1'b1, 1'b1, 1'b1, int'(COORD_MAX), int'(COORD_MIN), 1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 16;
    snk_idle_pct = 46;
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_REG) begin
        write_reg(directed_steps[i].idx, longint'(directed_steps[i].value));
      end else begin
        push_point(directed_steps[i].side, directed_steps[i].pv,
                   coord_t'(directed_steps[i].x), coord_t'(directed_steps[i].y),
                   coord_t'(directed_steps[i].z), directed_steps[i].from_model);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0, 5: set_box(longint'(COORD_MIN), longint'(COORD_MAX), HALF_TOP, longint'(COORD_MAX));
        2: set_box(longint'(COORD_MAX), longint'(COORD_MIN), 0, longint'(COORD_MIN));
        3: set_box(500, 20000, 12000, -1300);
        default: begin
          near = longint'($urandom_range(30000)) - 20000;
          set_box(near, near + 1 + longint'($urandom_range(80000)),
                  1 + longint'($urandom_range(70000)),
                  longint'($urandom_range(60000)) - 20000);
        end
      endcase
      src_idle_pct = phase < 2 ? 16 : (phase < 4 ? 46 : 0);
      snk_idle_pct = phase < 2 ? 46 : (phase < 4 ? 16 : 0);
      quota = phase == 2 ? 50 : 300;
      run_random(quota);
    end

    in_valid <= 1'b0;
    while (kept_points_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("lidar_point_ring_transform_crop_test: clean");
    end else begin
      $display("lidar_point_ring_transform_crop_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/lprtc_pkg.sv
sv/lprtc_elev.sv
sv/lprtc_xform.sv
sv/lprtc_crop.sv
sv/lidar_point_ring_transform_crop.sv
sv/lprtc_checker.sv
tb/sv/lidar_point_ring_transform_crop_test.sv
